FILE: sv/dmc_pkg.sv
// ----------------------------------------------------------------------------
// dmc_pkg
// Shared constants and types of the direct-mapped write-back cache.
// ----------------------------------------------------------------------------
package dmc_pkg;

  // default geometry
  localparam int DMC_SET_BITS  = 4;
  localparam int DMC_ADDR_BITS = 12;

  // fixed line format: 8 bytes of 8 bits
  localparam int DMC_OFF_BITS   = 3;
  localparam int DMC_LINE_BYTES = 8;
  localparam int DMC_BYTE_W     = 8;
  localparam int DMC_LINE_W     = 64;

  // operation codes of the func field
  localparam logic FUNC_READ  = 1'b0;
  localparam logic FUNC_WRITE = 1'b1;

  // sequencer states, one-hot
  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_LOOK  = 4'b0100,
    ST_HOLD  = 4'b1000
  } state_t;

endpackage

FILE: sv/dmc_if.sv
// ----------------------------------------------------------------------------
// dmc_if
// Request and response channel interfaces of the cache (valid/ready).
// ----------------------------------------------------------------------------
interface dmc_in_if
  import dmc_pkg::*;
#(
  parameter int ADDR_BITS = DMC_ADDR_BITS
);
  logic                  valid;
  logic                  ready;
  logic                  func;
  logic [ADDR_BITS-1:0]  address;
  logic [DMC_BYTE_W-1:0] write_data;

  modport source (output valid, func, address, write_data, input ready);
  modport sink   (input valid, func, address, write_data, output ready);
endinterface

interface dmc_out_if
  import dmc_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [DMC_BYTE_W-1:0] read_data;
  logic                  hit;
  logic                  wrote_back;

  modport source (output valid, read_data, hit, wrote_back, input ready);
  modport sink   (input valid, read_data, hit, wrote_back, output ready);
endinterface

FILE: sv/dmc_ram.sv
// ----------------------------------------------------------------------------
// dmc_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module dmc_ram
  import dmc_pkg::*;
#(
  parameter int WIDTH = DMC_LINE_W,
  parameter int DEPTH = 1 << DMC_SET_BITS,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port, holds its data while idle
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: sv/dmc_core.sv
// ----------------------------------------------------------------------------
// dmc_core
// Cache sequencer and datapath: tag compare, victim write-back, line fill,
// byte merge and result register, around the line RAM and backing RAM.
// ----------------------------------------------------------------------------
module dmc_core
  import dmc_pkg::*;
#(
  parameter int IDX_BITS  = DMC_SET_BITS,
  parameter int ADDR_BITS = DMC_ADDR_BITS,
  localparam int TAG_W      = ADDR_BITS - IDX_BITS - DMC_OFF_BITS,
  localparam int LINE_ABITS = ADDR_BITS - DMC_OFF_BITS,
  localparam int NUM_SETS   = 1 << IDX_BITS,
  localparam int CL_W       = TAG_W + DMC_LINE_W
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // request side
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_func,
  input  logic [ADDR_BITS-1:0]  in_address,
  input  logic [DMC_BYTE_W-1:0] in_write_data,
  // response side
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [DMC_BYTE_W-1:0] out_read_data,
  output logic                  out_hit,
  output logic                  out_wrote_back,
  // line ram (tag and data)
  output logic                  cl_we,
  output logic [IDX_BITS-1:0]   cl_waddr,
  output logic [CL_W-1:0]       cl_wdata,
  output logic                  cl_re,
  output logic [IDX_BITS-1:0]   cl_raddr,
  input  logic [CL_W-1:0]       cl_rdata,
  // backing ram
  output logic                  bm_we,
  output logic [LINE_ABITS-1:0] bm_waddr,
  output logic [DMC_LINE_W-1:0] bm_wdata,
  output logic                  bm_re,
  output logic [LINE_ABITS-1:0] bm_raddr,
  input  logic [DMC_LINE_W-1:0] bm_rdata
);

  state_t state_r, state_nxt;

  logic [LINE_ABITS-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [NUM_SETS-1:0]   valid_r, valid_nxt;
  logic [NUM_SETS-1:0]   dirty_r, dirty_nxt;

  // captured request
  logic                     func_r;
  logic [DMC_OFF_BITS-1:0]  off_r;
  logic [IDX_BITS-1:0]      set_r;
  logic [TAG_W-1:0]         tag_r;
  logic [DMC_BYTE_W-1:0]    wdata_r;

  // output register and parked result
  logic                  out_valid_r, out_valid_nxt;
  logic [DMC_BYTE_W-1:0] out_rdata_r;
  logic                  out_hit_r;
  logic                  out_wb_r;
  logic [DMC_BYTE_W-1:0] res_rdata_r;
  logic                  res_hit_r;
  logic                  res_wb_r;

  logic                  in_xfer;
  logic                  out_free;
  logic                  load_out;
  logic                  park_res;
  logic                  from_res;
  logic [TAG_W-1:0]      rd_tag;
  logic [DMC_LINE_W-1:0] rd_line;
  logic                  hit;
  logic                  wb;
  logic [DMC_LINE_W-1:0] base_line;
  logic [DMC_LINE_W-1:0] merged_line;
  logic [DMC_BYTE_W-1:0] rd_byte;
  logic [DMC_BYTE_W-1:0] res_rdata;

  assign in_ready = (state_r == ST_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  // tag compare and line selection in the lookup cycle
  assign rd_tag  = cl_rdata[CL_W-1 -: TAG_W];
  assign rd_line = cl_rdata[DMC_LINE_W-1:0];
  assign hit     = valid_r[set_r] && (rd_tag == tag_r);
  assign wb      = !hit && valid_r[set_r] && dirty_r[set_r];
  assign base_line = hit ? rd_line : bm_rdata;
  assign rd_byte   = base_line[{off_r, 3'b000} +: DMC_BYTE_W];
  assign res_rdata = (func_r == FUNC_WRITE) ? '0 : rd_byte;

  // byte merge of a write into the line
  always_comb begin
    merged_line = base_line;
    for (int b = 0; b < DMC_LINE_BYTES; b++) begin
      if (func_r == FUNC_WRITE && off_r == DMC_OFF_BITS'(b)) begin
        merged_line[b*DMC_BYTE_W +: DMC_BYTE_W] = wdata_r;
      end
    end
  end

  // memory read requests on a request transfer
  assign cl_re    = in_xfer;
  assign cl_raddr = in_address[DMC_OFF_BITS +: IDX_BITS];
  assign bm_re    = in_xfer;
  assign bm_raddr = in_address[ADDR_BITS-1:DMC_OFF_BITS];

  // line ram update on a fill or a write
  assign cl_we    = (state_r == ST_LOOK) && (!hit || func_r == FUNC_WRITE);
  assign cl_waddr = set_r;
  assign cl_wdata = {tag_r, merged_line};

  // backing ram: clearing pass, else victim write-back
  always_comb begin
    if (state_r == ST_CLEAR) begin
      bm_we    = 1'b1;
      bm_waddr = clr_cnt_r;
      bm_wdata = '0;
    end else begin
      bm_we    = (state_r == ST_LOOK) && wb;
      bm_waddr = {rd_tag, set_r};
      bm_wdata = rd_line;
    end
  end

  // sequencer
  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    valid_nxt   = valid_r;
    dirty_nxt   = dirty_r;
    load_out    = 1'b0;
    park_res    = 1'b0;
    from_res    = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (&clr_cnt_r) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_xfer) begin
          state_nxt = ST_LOOK;
        end
      end
      ST_LOOK: begin
        valid_nxt[set_r] = 1'b1;
        if (func_r == FUNC_WRITE) begin
          dirty_nxt[set_r] = 1'b1;
        end else if (!hit) begin
          dirty_nxt[set_r] = 1'b0;
        end
        if (out_free) begin
          load_out  = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          park_res  = 1'b1;
          state_nxt = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (out_ready) begin
          load_out  = 1'b1;
          from_res  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  // output valid
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      valid_r     <= '0;
      dirty_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      valid_r     <= valid_nxt;
      dirty_r     <= dirty_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      func_r  <= in_func;
      off_r   <= in_address[DMC_OFF_BITS-1:0];
      set_r   <= in_address[DMC_OFF_BITS +: IDX_BITS];
      tag_r   <= in_address[ADDR_BITS-1 -: TAG_W];
      wdata_r <= in_write_data;
    end
  end

  // result parked while the output register is full
  always_ff @(posedge clk) begin
    if (park_res) begin
      res_rdata_r <= res_rdata;
      res_hit_r   <= hit;
      res_wb_r    <= wb;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_rdata_r <= from_res ? res_rdata_r : res_rdata;
      out_hit_r   <= from_res ? res_hit_r   : hit;
      out_wb_r    <= from_res ? res_wb_r    : wb;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_read_data  = out_rdata_r;
  assign out_hit        = out_hit_r;
  assign out_wrote_back = out_wb_r;

endmodule

FILE: sv/direct_mapped_cache.sv
// ----------------------------------------------------------------------------
// direct_mapped_cache
// Direct-mapped, write-back, write-allocate byte cache with 8-byte lines and
// an internal line-wide backing memory.
// ----------------------------------------------------------------------------
//  channel  dir  transfer when       payload
//  in_ch    in   valid && ready      func, address, write_data
//  out_ch   out  valid && ready      read_data, hit, wrote_back
//
//  for each request the transfer cycle reads the line RAM and the backing
//  RAM, the next cycle compares, writes back, fills and merges.
//  one request at a time; a result waits in the output register while the
//  next request is taken, and a second result waits in a parked register.
//  after reset the backing memory is zeroed, one line a cycle, all
//  2^(ADDR_BITS-3) lines (512 by default), with in_ch.ready low.
// ----------------------------------------------------------------------------
module direct_mapped_cache
  import dmc_pkg::*;
#(
  parameter int IDX_BITS  = DMC_SET_BITS,
  parameter int ADDR_BITS = DMC_ADDR_BITS
) (
  input  logic       clk,
  input  logic       rst_n,
  dmc_in_if.sink     in_ch,
  dmc_out_if.source  out_ch
);

  localparam int TAG_W      = ADDR_BITS - IDX_BITS - DMC_OFF_BITS;
  localparam int LINE_ABITS = ADDR_BITS - DMC_OFF_BITS;
  localparam int CL_W       = TAG_W + DMC_LINE_W;

  logic                  cl_we;
  logic [IDX_BITS-1:0]   cl_waddr;
  logic [CL_W-1:0]       cl_wdata;
  logic                  cl_re;
  logic [IDX_BITS-1:0]   cl_raddr;
  logic [CL_W-1:0]       cl_rdata;
  logic                  bm_we;
  logic [LINE_ABITS-1:0] bm_waddr;
  logic [DMC_LINE_W-1:0] bm_wdata;
  logic                  bm_re;
  logic [LINE_ABITS-1:0] bm_raddr;
  logic [DMC_LINE_W-1:0] bm_rdata;

  // sequencer and datapath
  dmc_core #(
    .IDX_BITS  (IDX_BITS),
    .ADDR_BITS (ADDR_BITS)
  ) u_core (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_ch.valid),
    .in_ready       (in_ch.ready),
    .in_func        (in_ch.func),
    .in_address     (in_ch.address),
    .in_write_data  (in_ch.write_data),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .out_read_data  (out_ch.read_data),
    .out_hit        (out_ch.hit),
    .out_wrote_back (out_ch.wrote_back),
    .cl_we          (cl_we),
    .cl_waddr       (cl_waddr),
    .cl_wdata       (cl_wdata),
    .cl_re          (cl_re),
    .cl_raddr       (cl_raddr),
    .cl_rdata       (cl_rdata),
    .bm_we          (bm_we),
    .bm_waddr       (bm_waddr),
    .bm_wdata       (bm_wdata),
    .bm_re          (bm_re),
    .bm_raddr       (bm_raddr),
    .bm_rdata       (bm_rdata)
  );

  // tag and data of each set
  dmc_ram #(
    .WIDTH (CL_W),
    .DEPTH (1 << IDX_BITS)
  ) u_line_ram (
    .clk   (clk),
    .we    (cl_we),
    .waddr (cl_waddr),
    .wdata (cl_wdata),
    .re    (cl_re),
    .raddr (cl_raddr),
    .rdata (cl_rdata)
  );

  // backing memory, one line per entry
  dmc_ram #(
    .WIDTH (DMC_LINE_W),
    .DEPTH (1 << LINE_ABITS)
  ) u_back_ram (
    .clk   (clk),
    .we    (bm_we),
    .waddr (bm_waddr),
    .wdata (bm_wdata),
    .re    (bm_re),
    .raddr (bm_raddr),
    .rdata (bm_rdata)
  );

endmodule

FILE: sv/dmc_checker.sv
// ----------------------------------------------------------------------------
// dmc_checker
// Port-level checks of the cache, bound to the top level.
// ----------------------------------------------------------------------------
module dmc_checker
  import dmc_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [DMC_BYTE_W-1:0] out_read_data,
  input logic                  out_hit,
  input logic                  out_wrote_back
);

  // one request in flight: no transfer right after a transfer
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request taken while previous one still in work");

  // a new result rises on out_valid from the lookup state that follows its request transfer
  a_result_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result without a request");

  // a write-back only happens on a miss
  a_wb_on_miss: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_wrote_back) |-> !out_hit)
    else $error("write-back reported on a hit");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_read_data) && $stable(out_hit) &&
       $stable(out_wrote_back)))
    else $error("stalled result changed");

  // clearing pass after reset: no result, no request taken
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> (!out_valid && !in_ready))
    else $error("channel active right after reset");

endmodule

bind direct_mapped_cache dmc_checker u_dmc_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_read_data  (out_ch.read_data),
  .out_hit        (out_ch.hit),
  .out_wrote_back (out_ch.wrote_back)
);

FILE: tb/sv/dmc_tb_pkg.sv
// ----------------------------------------------------------------------------
// dmc_tb_pkg
// Response type and scoreboard of the cache testbench. The scoreboard keeps
// its own image of the cache lines and the backing memory, predicts the
// response of every accepted access and checks responses in order.
// ----------------------------------------------------------------------------
package dmc_tb_pkg;
  import dmc_pkg::*;

  localparam int TB_TAG_BITS  = DMC_ADDR_BITS - DMC_SET_BITS - DMC_OFF_BITS;
  localparam int TB_NUM_SETS  = 1 << DMC_SET_BITS;
  localparam int TB_MEM_LINES = 1 << (DMC_ADDR_BITS - DMC_OFF_BITS);
  localparam int MAX_REPORTS  = 10;

  typedef logic [DMC_ADDR_BITS-1:0] addr_t;
  typedef logic [DMC_BYTE_W-1:0]    byte_t;

  typedef struct packed {
    byte_t read_data;
    logic  hit;
    logic  wrote_back;
  } cache_resp_t;

  class cache_scoreboard;
    bit                     line_valid   [TB_NUM_SETS];
    bit                     line_dirty   [TB_NUM_SETS];
    logic [TB_TAG_BITS-1:0] line_tag     [TB_NUM_SETS];
    logic [DMC_LINE_W-1:0]  line_data    [TB_NUM_SETS];
    logic [DMC_LINE_W-1:0]  memory_image [TB_MEM_LINES];
    cache_resp_t            expected_responses[$];
    int unsigned            response_count;
    int unsigned            mismatch_count;

    function new();
      foreach (line_valid[i]) begin
        line_valid[i] = 1'b0;
        line_dirty[i] = 1'b0;
        line_tag[i]   = '0;
        line_data[i]  = '0;
      end
      foreach (memory_image[i]) memory_image[i] = '0;
      response_count = 0;
      mismatch_count = 0;
    endfunction

    // predict the response of one accepted access and update the image
    function void note_access(logic func, addr_t address, byte_t wdata);
      logic [DMC_OFF_BITS-1:0] offset;
      logic [DMC_SET_BITS-1:0] set_idx;
      logic [TB_TAG_BITS-1:0]  tag;
      cache_resp_t             resp;
      offset  = address[DMC_OFF_BITS-1:0];
      set_idx = address[DMC_OFF_BITS +: DMC_SET_BITS];
      tag     = address[DMC_ADDR_BITS-1 -: TB_TAG_BITS];
      resp    = '0;
      resp.hit = line_valid[set_idx] && (line_tag[set_idx] == tag);

      // miss: evict a dirty victim at its own line address, then fill
      if (!resp.hit) begin
        if (line_valid[set_idx] && line_dirty[set_idx]) begin
          memory_image[{line_tag[set_idx], set_idx}] = line_data[set_idx];
          resp.wrote_back = 1'b1;
        end
        line_data[set_idx]  = memory_image[address[DMC_ADDR_BITS-1:DMC_OFF_BITS]];
        line_tag[set_idx]   = tag;
        line_valid[set_idx] = 1'b1;
        line_dirty[set_idx] = 1'b0;
      end

      // byte merge on write, byte select on read
      if (func == FUNC_WRITE) begin
        line_data[set_idx][offset*DMC_BYTE_W +: DMC_BYTE_W] = wdata;
        line_dirty[set_idx] = 1'b1;
      end else begin
        resp.read_data = line_data[set_idx][offset*DMC_BYTE_W +: DMC_BYTE_W];
      end
      expected_responses = {expected_responses, resp};
    endfunction

    // compare one response with the oldest prediction
    function void check_response(cache_resp_t got);
      cache_resp_t want;
      response_count++;
      if (expected_responses.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("mismatch: response %0d arrived with nothing outstanding",
                   response_count);
        return;
      end
      want = expected_responses.pop_front();
      if (got.read_data !== want.read_data || got.hit !== want.hit ||
          got.wrote_back !== want.wrote_back) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("mismatch: response %0d read_data %02h/%02h hit %0b/%0b %s %0b/%0b",
                   response_count, want.read_data, got.read_data, want.hit,
                   got.hit, "wrote_back (exp/got)", want.wrote_back,
                   got.wrote_back);
      end
    endfunction

    function int pending();
      return expected_responses.size();
    endfunction
  endclass

endpackage

FILE: tb/sv/tb_direct_mapped_cache.sv
// ----------------------------------------------------------------------------
// tb_direct_mapped_cache
// Self-checking testbench of the direct-mapped write-back cache. A directed
// run covers hits, clean and dirty misses, refetch of written-back lines and
// the address and data extremes; a random run follows with random gaps on
// both channels, a long output stall and a full drain in the middle.
// ----------------------------------------------------------------------------
module tb_direct_mapped_cache;
  import dmc_pkg::*;
  import dmc_tb_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ACCESSES = 1600;
  localparam int CYCLE_LIMIT     = 200000;
  localparam int HOLD_AT         = 300;
  localparam int HOLD_CYCLES     = 400;
  localparam int SETTLE_CYCLES   = 10;

  logic clk = 1'b0;
  logic rst_n;
  bit   tx_eager;

  cache_scoreboard sb;

  dmc_in_if  in_ch ();
  dmc_out_if out_ch ();

  direct_mapped_cache i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // observe transfers on both channels
  always @(posedge clk) begin
    cache_resp_t seen;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready)
        sb.note_access(in_ch.func, in_ch.address, in_ch.write_data);
      if (out_ch.valid && out_ch.ready) begin
        seen.read_data  = out_ch.read_data;
        seen.hit        = out_ch.hit;
        seen.wrote_back = out_ch.wrote_back;
        sb.check_response(seen);
      end
    end
  end

  // offer one access, return at the edge of its transfer
  task automatic send_access(input logic func, input addr_t address, input byte_t wdata);
    int gap;
    gap = tx_eager ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.func       <= func;
    in_ch.address    <= address;
    in_ch.write_data <= wdata;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // stop offering until every predicted response has come back
  task automatic drain_responses();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // response side: random stalls, stretches without stalls, one long hold
  initial begin
    int unsigned rx_count;
    int          stall;
    bit          rx_eager;
    rx_count = 0;
    rx_eager = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      if (rx_count % 50 == 0)
        rx_eager = ($urandom_range(0, 3) == 0);
      if (rx_count == HOLD_AT)
        stall = HOLD_CYCLES;
      else
        stall = rx_eager ? 0 : $urandom_range(0, 10);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      rx_count++;
    end
  end

  // watchdog
  initial begin
    int unsigned cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL direct_mapped_cache");
    $finish;
  end

  // stimulus
  initial begin
    logic  func;
    addr_t address;
    sb = new();
    tx_eager = 1'b0;
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.func       <= FUNC_READ;
    in_ch.address    <= '0;
    in_ch.write_data <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // cold miss, hits on both ends of a line
    send_access(FUNC_READ,  12'h000, 8'h00);
    send_access(FUNC_WRITE, 12'h000, 8'hFF);
    send_access(FUNC_WRITE, 12'h007, 8'h5A);
    send_access(FUNC_READ,  12'h007, 8'h00);
    // dirty eviction, then refetch of the written-back line
    send_access(FUNC_READ,  12'h080, 8'hFF);
    send_access(FUNC_READ,  12'h000, 8'h00);
    send_access(FUNC_READ,  12'h007, 8'h00);
    // top set and top tag
    send_access(FUNC_WRITE, 12'hFFF, 8'h00);
    send_access(FUNC_WRITE, 12'hFFF, 8'hFF);
    send_access(FUNC_READ,  12'hFFF, 8'h00);
    send_access(FUNC_WRITE, 12'h7F8, 8'hA5);
    send_access(FUNC_READ,  12'hFFF, 8'h00);
    send_access(FUNC_READ,  12'h7F8, 8'h00);
    // alternating bit patterns
    send_access(FUNC_WRITE, 12'h555, 8'hAA);
    send_access(FUNC_WRITE, 12'hAAA, 8'h55);
    send_access(FUNC_READ,  12'h555, 8'h00);
    send_access(FUNC_READ,  12'hAAA, 8'h00);
    // write hit with zero data on a clean refetched line
    send_access(FUNC_WRITE, 12'h000, 8'h00);
    send_access(FUNC_READ,  12'h000, 8'h00);
    drain_responses();

    // random accesses, mostly on a few tags so that lines collide
    for (int i = 0; i < RANDOM_ACCESSES; i++) begin
      if (i % 40 == 0)
        tx_eager = ($urandom_range(0, 3) == 0);
      if (i == RANDOM_ACCESSES / 2)
        drain_responses();
      func = $urandom_range(0, 1) ? FUNC_WRITE : FUNC_READ;
      if ($urandom_range(0, 9) < 7)
        address = {TB_TAG_BITS'($urandom_range(0, 3)), DMC_SET_BITS'($urandom),
                   DMC_OFF_BITS'($urandom)};
      else
        address = addr_t'($urandom);
      send_access(func, address, byte_t'($urandom));
    end

    drain_responses();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.mismatch_count == 0 && sb.pending() == 0)
      $display("PASS direct_mapped_cache");
    else
      $display("FAIL direct_mapped_cache");
    $finish;
  end

endmodule
